### hw/rtl/swd_wte_pkg.sv
// Shared types and constants for the serial wire debug write transfer engine.
package swd_wte_pkg;

	// Bit counts of the transfer phases.
	localparam int unsigned REQ_BITS  = 8;
	localparam int unsigned ACK_BITS  = 3;
	localparam int unsigned DATA_BITS = 32;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TURNAROUND  = 1'b1;

	// Transfer phases.
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_REQ,
		PH_TURN1,
		PH_ACK,
		PH_TURN2,
		PH_DATA
	} phase_t;

	// One input beat: one tick of the sequencer.
	typedef struct packed {
		logic        cmd;
		logic [3:0]  request;
		logic [31:0] wdata;
		logic        line_in;
	} in_t;

	// One result beat: pin levels and status for that tick.
	typedef struct packed {
		logic       clock_out;
		logic       line_out;
		logic       line_drive;
		logic       busy_res;
		logic       done_res;
		logic [2:0] ack_code;
	} out_t;

	// Effective configuration, zero values already mapped to one.
	typedef struct packed {
		logic [7:0] half_ticks;
		logic [2:0] turn_bits;
	} cfg_t;

endpackage

### hw/rtl/swd_wte_cfg.sv
// Configuration registers of the transfer engine.
module swd_wte_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [swd_wte_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                         cfg_data,
	output swd_wte_pkg::cfg_t                  cfg
);
	import swd_wte_pkg::*;

	logic [7:0] half_q;
	logic [2:0] turn_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= 8'd1;
			turn_q <= 3'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_HALF_PERIOD: half_q <= cfg_data;
				CFG_TURNAROUND:  turn_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// A zero count behaves as one.
	assign cfg.half_ticks = (half_q == 8'd0) ? 8'd1 : half_q;
	assign cfg.turn_bits  = (turn_q == 3'd0) ? 3'd1 : turn_q;

endmodule

### hw/rtl/swd_wte_seq.sv
// Transfer sequencer: state registers and the logic of one tick.
module swd_wte_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  swd_wte_pkg::in_t   item,
	input  swd_wte_pkg::cfg_t  cfg,
	output swd_wte_pkg::out_t  res
);
	import swd_wte_pkg::*;

	phase_t      phase_q;
	logic [5:0]  bit_count_q;
	logic [7:0]  tick_count_q;
	logic        high_half_q;
	logic [31:0] shift_q;
	logic [3:0]  request_q;
	logic        parity_q;
	logic [2:0]  ack_q;

	phase_t      phase_d;
	logic [5:0]  bit_count_d;
	logic [7:0]  tick_count_d;
	logic        high_half_d;
	logic [31:0] shift_d;
	logic [3:0]  request_d;
	logic        parity_d;
	logic [2:0]  ack_d;

	logic        start;
	logic        half_end;
	logic [5:0]  bit_next;
	logic        bitval;
	logic        in_data_bits;

	// Tick logic; a start beat is already the first tick of the start bit.
	always_comb begin
		start = (phase_q == PH_IDLE) && item.cmd;

		phase_d      = start ? PH_REQ : phase_q;
		bit_count_d  = start ? 6'd0 : bit_count_q;
		tick_count_d = start ? 8'd0 : tick_count_q;
		high_half_d  = start ? 1'b0 : high_half_q;
		shift_d      = start ? item.wdata : shift_q;
		request_d    = start ? item.request : request_q;
		parity_d     = start ? 1'b0 : parity_q;
		ack_d        = start ? 3'd0 : ack_q;

		res = '0;
		res.clock_out  = 1'b1;
		res.line_out   = 1'b1;
		res.line_drive = 1'b1;

		half_end     = ({1'b0, tick_count_d} + 9'd1) >= {1'b0, cfg.half_ticks};
		bit_next     = bit_count_d + 6'd1;
		in_data_bits = bit_count_d < 6'(DATA_BITS);
		bitval       = 1'b1;

		if (phase_d != PH_IDLE) begin
			res.busy_res  = 1'b1;
			res.clock_out = high_half_d;

			// Level on the data line for the current bit.
			unique case (phase_d)
				PH_REQ: begin
					unique case (bit_count_d[2:0])
						3'd0: bitval = 1'b1;
						3'd1: bitval = request_d[0];
						3'd2: bitval = request_d[1];
						3'd3: bitval = request_d[2];
						3'd4: bitval = request_d[3];
						3'd5: bitval = ^request_d;
						3'd6: bitval = 1'b0;
						3'd7: bitval = 1'b1;
						default: bitval = 1'b1;
					endcase
				end
				PH_DATA: bitval = in_data_bits ? shift_d[0] : parity_d;
				default: res.line_drive = 1'b0;
			endcase
			res.line_out = bitval;

			// Ack bits are sampled on the last tick of the clock-low half.
			if (phase_d == PH_ACK && !high_half_d && half_end &&
			    bit_count_d < 6'(ACK_BITS)) begin
				ack_d[bit_count_d[1:0]] = item.line_in;
			end

			// Tick, half and bit counting with phase advance.
			if (!half_end) begin
				tick_count_d = tick_count_d + 8'd1;
			end else begin
				tick_count_d = 8'd0;
				if (!high_half_d) begin
					high_half_d = 1'b1;
				end else begin
					high_half_d = 1'b0;
					if (phase_d == PH_DATA && in_data_bits) begin
						parity_d = parity_d ^ shift_d[0];
						shift_d  = {1'b0, shift_d[31:1]};
					end
					bit_count_d = bit_next;
					unique case (phase_d)
						PH_REQ: begin
							if (bit_next >= 6'(REQ_BITS)) begin
								phase_d     = PH_TURN1;
								bit_count_d = 6'd0;
							end
						end
						PH_TURN1: begin
							if (bit_next >= {3'd0, cfg.turn_bits}) begin
								phase_d     = PH_ACK;
								bit_count_d = 6'd0;
							end
						end
						PH_ACK: begin
							if (bit_next >= 6'(ACK_BITS)) begin
								phase_d     = PH_TURN2;
								bit_count_d = 6'd0;
							end
						end
						PH_TURN2: begin
							if (bit_next >= {3'd0, cfg.turn_bits}) begin
								phase_d     = PH_DATA;
								bit_count_d = 6'd0;
							end
						end
						default: begin
							if (bit_next > 6'(DATA_BITS)) begin
								phase_d      = PH_IDLE;
								bit_count_d  = 6'd0;
								high_half_d  = 1'b1;
								res.done_res = 1'b1;
								res.ack_code = ack_d;
							end
						end
					endcase
				end
			end
		end
	end

	// State registers, updated once per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= 6'd0;
			tick_count_q <= 8'd0;
			high_half_q  <= 1'b1;
			shift_q      <= 32'd0;
			request_q    <= 4'd0;
			parity_q     <= 1'b0;
			ack_q        <= 3'd0;
		end else if (step) begin
			phase_q      <= phase_d;
			bit_count_q  <= bit_count_d;
			tick_count_q <= tick_count_d;
			high_half_q  <= high_half_d;
			shift_q      <= shift_d;
			request_q    <= request_d;
			parity_q     <= parity_d;
			ack_q        <= ack_d;
		end
	end

endmodule

### hw/rtl/swd_write_transfer_engine_top.sv
// Top level of the serial wire debug write transfer engine.
//
//   port group   direction  handshake          payload
//   in_*         input      in_valid/in_stall  in_data (in_t), one tick per beat
//   out_*        output     out_valid/out_stall out_data (out_t), one per input beat
//   cfg_*        input      cfg_write          cfg_index, cfg_data
//
// Every input beat is one sequencer tick and yields one result beat via the input register
// and then the result register. One beat is taken per cycle unless the result side stalls;
// the tick logic between the two registers is the only path a beat passes through.
// Reset puts the engine idle with clock and data line high, half period one tick
// and turnaround one period.
// A stalled result register holds its beat and stalls the input register behind it.
module swd_write_transfer_engine_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  swd_wte_pkg::in_t                   in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output swd_wte_pkg::out_t                  out_data,
	input  logic                               cfg_write,
	input  logic [swd_wte_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                         cfg_data
);
	import swd_wte_pkg::*;

	cfg_t cfg;
	in_t  item_s1;
	logic vld_s1;
	out_t res;
	out_t res_s2;
	logic vld_s2;
	logic adv;

	swd_wte_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// A held beat moves on when the result register is free or being emptied.
	assign adv      = vld_s1 && (!vld_s2 || !out_stall);
	assign in_stall = vld_s1 && !adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	swd_wte_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = res_s2;

`ifndef ASSERT_OFF
	// A tick that moves on always leaves a result beat behind.
	a_adv_fills: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> vld_s2)
		else $error("tick advanced without a result beat");

	// The input side stalls only behind a blocked result beat.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (vld_s2 && out_stall))
		else $error("input stalled while result register could take a beat");

	// A finishing tick reports busy with the clock high.
	a_done_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.done_res) |-> (res.busy_res && res.clock_out))
		else $error("done tick without busy and clock high");

	// The ack code is only shown on the finishing tick.
	a_ack_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && !res.done_res) |=> (res_s2.ack_code == 3'd0))
		else $error("ack code shown outside the done tick");
`endif

endmodule
